@@ rtl/eic_pkg.sv @@
`default_nettype none

package eic_pkg;

	localparam int TIME_BITS     = 32;
	localparam int INTERVAL_BITS = 16;
	localparam int COUNT_BITS    = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [TIME_BITS-1:0] INTERVAL_MAX =
		{TIME_BITS{1'b1}} >> (TIME_BITS - INTERVAL_BITS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// register indexes on the config port
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_EDGES     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_EDGES_TO  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SILENCE_LIMIT = 2'd2;

	// op codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_START  = 1'b1;

	localparam logic [COUNT_BITS-1:0] MAX_EDGES_RST     = COUNT_BITS'(2000);
	localparam logic [COUNT_BITS-1:0] MIN_EDGES_TO_RST  = COUNT_BITS'(10);
	localparam logic [TIME_BITS-1:0]  SILENCE_LIMIT_RST = TIME_BITS'(2000000);

	typedef struct packed {
		logic                 op;
		logic                 pin_level;
		logic [TIME_BITS-1:0] time_us;
	} in_word_t;

	typedef struct packed {
		logic                     has_interval;
		logic [INTERVAL_BITS-1:0] interval_us;
		logic                     capture_done;
		logic [COUNT_BITS-1:0]    edges_seen;
	} out_word_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] max_edges;
		logic [COUNT_BITS-1:0] min_edges_for_timeout;
		logic [TIME_BITS-1:0]  silence_limit_us;
	} cfg_t;

	typedef struct packed {
		logic                  armed;
		logic                  prev_level;
		logic [TIME_BITS-1:0]  prev_edge_time;
		logic [COUNT_BITS-1:0] edge_count;
	} cap_state_t;

endpackage

`default_nettype wire

@@ rtl/eic_step.sv @@
`default_nettype none

// One capture step: next state and optional result word for one input word.
module eic_step (
	input  wire eic_pkg::cap_state_t state,
	input  wire eic_pkg::in_word_t   word,
	input  wire eic_pkg::cfg_t       cfg,
	output eic_pkg::cap_state_t      state_next,
	output eic_pkg::out_word_t       res,
	output logic                     res_valid
);

	logic                                   sample;
	logic                                   edge_hit;
	logic [eic_pkg::TIME_BITS-1:0]          elapsed;
	logic [eic_pkg::INTERVAL_BITS-1:0]      interval;
	logic [eic_pkg::COUNT_BITS-1:0]         count_new;
	logic                                   done_count;
	logic                                   done_silence;
	logic                                   done;

	always_comb begin
		sample   = state.armed && (word.op == eic_pkg::OP_SAMPLE);
		edge_hit = sample && (word.pin_level != state.prev_level);
		elapsed  = word.time_us - state.prev_edge_time;

		if (elapsed > eic_pkg::INTERVAL_MAX) begin
			interval = eic_pkg::INTERVAL_MAX[eic_pkg::INTERVAL_BITS-1:0];
		end else begin
			interval = elapsed[eic_pkg::INTERVAL_BITS-1:0];
		end

		if (edge_hit && (state.edge_count != eic_pkg::COUNT_MAX)) begin
			count_new = state.edge_count + 1'b1;
		end else begin
			count_new = state.edge_count;
		end

		done_count   = edge_hit && (count_new > cfg.max_edges);
		// on an edge the elapsed time restarts at zero, so silence only fires without one
		done_silence = sample && !edge_hit &&
			(state.edge_count > cfg.min_edges_for_timeout) &&
			(elapsed > cfg.silence_limit_us);
		done         = done_count || done_silence;
	end

	always_comb begin
		state_next = state;
		if (word.op == eic_pkg::OP_START) begin
			state_next.armed          = 1'b1;
			state_next.prev_level     = word.pin_level;
			state_next.prev_edge_time = word.time_us;
			state_next.edge_count     = '0;
		end else if (state.armed) begin
			state_next.armed = !done;
			if (edge_hit) begin
				state_next.prev_level     = word.pin_level;
				state_next.prev_edge_time = word.time_us;
				state_next.edge_count     = count_new;
			end
		end
	end

	always_comb begin
		res_valid        = edge_hit || done;
		res.has_interval = edge_hit;
		res.interval_us  = edge_hit ? interval : '0;
		res.capture_done = done;
		res.edges_seen   = count_new;
	end

endmodule

`default_nettype wire

@@ rtl/edge_interval_capture.sv @@
`default_nettype none

// Edge interval capture on a demodulated data pin.
// A word taken into stage 1 gives its result word at out_valid once it leaves stage 1.
// Throughput: one word per cycle (the single capture-state update per cycle) when the
// input is not stalled; a waiting result stalls it only if stage 1 makes a result too.
// Reset (arst_n low, async): capture disarmed, counters and reference cleared,
// config registers back to max_edges=2000, min_edges_for_timeout=10, silence=2000000us.
module edge_interval_capture (
	input  wire                                  clk,
	input  wire                                  arst_n,

	input  wire                                  sample_valid,
	output logic                                 sample_stall,
	input  wire eic_pkg::in_word_t               sample,

	output logic                                 result_valid,
	input  wire                                  result_stall,
	output eic_pkg::out_word_t                   result,

	input  wire                                  cfg_we,
	input  wire [eic_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire [eic_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	// config registers
	eic_pkg::cfg_t       cfg_q;

	// input stage
	logic                valid_s1;
	eic_pkg::in_word_t   word_s1;

	// capture state
	eic_pkg::cap_state_t state_q;
	eic_pkg::cap_state_t state_next;

	// result of the step logic
	eic_pkg::out_word_t  res;
	logic                res_valid;

	// output register
	logic                out_valid_q;
	eic_pkg::out_word_t  out_word_q;

	logic                out_free;
	logic                advance;
	logic                take_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_edges             <= eic_pkg::MAX_EDGES_RST;
			cfg_q.min_edges_for_timeout <= eic_pkg::MIN_EDGES_TO_RST;
			cfg_q.silence_limit_us      <= eic_pkg::SILENCE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				eic_pkg::REG_MAX_EDGES: begin
					cfg_q.max_edges <= cfg_data[eic_pkg::COUNT_BITS-1:0];
				end
				eic_pkg::REG_MIN_EDGES_TO: begin
					cfg_q.min_edges_for_timeout <= cfg_data[eic_pkg::COUNT_BITS-1:0];
				end
				eic_pkg::REG_SILENCE_LIMIT: begin
					cfg_q.silence_limit_us <= cfg_data[eic_pkg::TIME_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	eic_step u_step (
		.state      (state_q),
		.word       (word_s1),
		.cfg        (cfg_q),
		.state_next (state_next),
		.res        (res),
		.res_valid  (res_valid)
	);

	// Stage 1 moves on when its result (if any) has somewhere to go.
	assign out_free     = !out_valid_q || !result_stall;
	assign advance      = valid_s1 && (out_free || !res_valid);
	assign sample_stall = valid_s1 && !advance;
	assign take_in      = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in || advance) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= sample;
		end
	end

	// capture state follows every word leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_word_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_word_q;

	// a finished capture leaves the block disarmed
	a_done_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res.capture_done) |=> !state_q.armed)
		else $error("capture still armed after end of run");

	// results only come out of an armed capture
	a_res_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid) |-> state_q.armed)
		else $error("result while not armed");

	// a word without an interval is only the silence end marker
	a_timeout_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_word_q.has_interval) |->
			(out_word_q.capture_done && out_word_q.interval_us == '0))
		else $error("empty result word that is not an end marker");

	// input stalls only when stage 1 is occupied and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && res_valid && out_valid_q && result_stall))
		else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

@@ tb/tb_edge_interval_capture.sv @@
`timescale 1ns / 100ps

// Edge interval capture testbench.
// Sample words go in from a queue through a clocked driver. Each accepted word runs
// through a local capture predictor, and any result it makes is queued as expected.
// A clocked monitor checks result words field by field against that queue.
// Registers are only reprogrammed once the pipe has drained.
module tb_edge_interval_capture;
	import eic_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;    // result is one register past acceptance
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off under pressure
	localparam int RESULT_WAIT = 2000;  // bound on waiting for outstanding results

	logic clk;
	logic arst_n = 1'b0;

	logic sample_valid = 1'b0;
	logic sample_stall;
	in_word_t sample = '0;

	logic result_valid;
	logic result_stall = 1'b0;
	out_word_t result;

	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	edge_interval_capture dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Queued sample words and expected capture results.
	in_word_t pending_samples[$];
	out_word_t expected_captures[$];

	// Local copy of the capture state and the registers.
	cap_state_t cap = '0;
	cfg_t regs = '{MAX_EDGES_RST, MIN_EDGES_TO_RST, SILENCE_LIMIT_RST};

	int errors = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;        // no random idling on either side
	bit pressure_on = 1'b0;  // monitor does one long hold-off
	bit hold_used = 1'b0;
	int hold_left = 0;
	logic [31:0] stamp_us = 32'h0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Predictor: one capture step for an accepted word. Returns 1 when a result is due.
	function automatic logic predict_capture(input in_word_t w, output out_word_t r);
		logic toggled;
		logic done;
		logic [TIME_BITS-1:0] gap;
		logic [TIME_BITS-1:0] quiet_for;
		logic [INTERVAL_BITS-1:0] width;
		toggled = 1'b0;
		done = 1'b0;
		width = '0;
		r = '0;
		// start (re)arms and takes the reference from the word
		if (w.op == OP_START) begin
			cap.armed = 1'b1;
			cap.prev_level = w.pin_level;
			cap.prev_edge_time = w.time_us;
			cap.edge_count = '0;
			return 1'b0;
		end
		if (!cap.armed)
			return 1'b0;
		if (w.pin_level != cap.prev_level) begin
			gap = w.time_us - cap.prev_edge_time;  // modular 32-bit
			if (gap > INTERVAL_MAX)
				width = '1;
			else
				width = gap[INTERVAL_BITS-1:0];
			if (cap.edge_count != COUNT_MAX)
				cap.edge_count = cap.edge_count + 1'b1;
			cap.prev_level = w.pin_level;
			cap.prev_edge_time = w.time_us;
			toggled = 1'b1;
			if (cap.edge_count > regs.max_edges)
				done = 1'b1;
		end
		quiet_for = w.time_us - cap.prev_edge_time;
		if (!done && cap.edge_count > regs.min_edges_for_timeout &&
				quiet_for > regs.silence_limit_us)
			done = 1'b1;
		if (done)
			cap.armed = 1'b0;
		if (!toggled && !done)
			return 1'b0;
		r.has_interval = toggled;
		r.interval_us = width;
		r.capture_done = done;
		r.edges_seen = cap.edge_count;
		return 1'b1;
	endfunction

	// Driver: holds a stalled word, otherwise loads the next one unless idling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
		end else begin : drive
			out_word_t r;
			logic taken;
			logic idle;
			taken = sample_valid && !sample_stall;
			idle = !quiet && ($urandom_range(0, 99) < 10);
			if (taken && predict_capture(sample, r))
				expected_captures = {expected_captures, r};
			if (sample_valid && !taken) begin
				// stalled: word stays put
			end else if (pending_samples.size() != 0 && !idle) begin
				sample <= pending_samples.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Monitor: checks accepted results, drives random stall and the one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left = 0;
		end else begin : watch
			out_word_t want;
			if (result_valid && !result_stall) begin
				if (expected_captures.size() == 0) begin
					$error("result word with nothing expected: %h", result);
					errors++;
				end else begin
					want = expected_captures.pop_front();
					check_field("has_interval", 32'(want.has_interval),
						32'(result.has_interval));
					check_field("interval_us", 32'(want.interval_us),
						32'(result.interval_us));
					check_field("capture_done", 32'(want.capture_done),
						32'(result.capture_done));
					check_field("edges_seen", 32'(want.edges_seen),
						32'(result.edges_seen));
				end
			end
			if (hold_left > 0)
				hold_left--;
			else if (pressure_on && !hold_used) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			result_stall <= (hold_left > 0) || (!quiet && $urandom_range(0, 99) < 10);
		end
	end

	task automatic add_word(input logic op, input logic lvl, input logic [31:0] t);
		in_word_t w;
		w.op = op;
		w.pin_level = lvl;
		w.time_us = t;
		pending_samples = {pending_samples, w};
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_MAX_EDGES: regs.max_edges = data[COUNT_BITS-1:0];
			REG_MIN_EDGES_TO: regs.min_edges_for_timeout = data[COUNT_BITS-1:0];
			REG_SILENCE_LIMIT: regs.silence_limit_us = data;
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [11:0] max_e, input logic [11:0] min_e,
			input logic [31:0] silence);
		write_reg(REG_MAX_EDGES, 32'(max_e));
		write_reg(REG_MIN_EDGES_TO, 32'(min_e));
		write_reg(REG_SILENCE_LIMIT, silence);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every word to be taken and every result to come back, then let the
	// pipe empty of words that make no result.
	task automatic drain();
		int waited;
		waited = 0;
		while (pending_samples.size() != 0 || sample_valid)
			@(posedge clk);
		while (expected_captures.size() != 0 && waited < RESULT_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Time step between samples: mostly short pulses, some long, some saturating,
	// some far enough to trip the silence timeout, a few anywhere.
	function automatic logic [31:0] step_us();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return 32'd0;
		else if (pick < 65)
			return $urandom_range(1, 800);
		else if (pick < 88)
			return $urandom_range(800, 70000);
		else if (pick < 96)
			return $urandom_range(70000, 5000000);
		return $urandom;
	endfunction

	// One well-formed capture run: start, then mostly toggling samples with a
	// sprinkle of junk words mixed in.
	task automatic queue_capture(input int n);
		logic lvl;
		lvl = 1'($urandom_range(0, 1));
		stamp_us = stamp_us + step_us();
		add_word(OP_START, lvl, stamp_us);
		repeat (n) begin
			if ($urandom_range(0, 99) < 8) begin
				add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
			end else begin
				if ($urandom_range(0, 99) < 75)
					lvl = ~lvl;
				stamp_us = stamp_us + step_us();
				add_word(OP_SAMPLE, lvl, stamp_us);
			end
		end
	endtask

	task automatic random_phase(input int words);
		int target;
		target = words;
		while (target > 0) begin
			int n;
			n = $urandom_range(4, 40);
			queue_capture(n);
			target -= n + 1;
		end
	endtask

	initial begin
		int n;
		logic lvl;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset register values: idle sample, wrap, zero and saturated
		// intervals, exact 65535, restart while armed.
		add_word(OP_SAMPLE, 1'b1, 32'h0000_1234);  // ignored, not armed
		add_word(OP_START, 1'b0, 32'hFFFF_FFF0);
		add_word(OP_SAMPLE, 1'b0, 32'hFFFF_FFF8);  // no edge
		add_word(OP_SAMPLE, 1'b1, 32'h0000_0010);  // timestamp wraps
		add_word(OP_SAMPLE, 1'b0, 32'h0000_0010);  // zero interval
		add_word(OP_SAMPLE, 1'b1, 32'h0001_0010);  // saturates
		add_word(OP_SAMPLE, 1'b0, 32'h0002_000F);  // exactly full scale
		add_word(OP_START, 1'b1, 32'h8000_0000);   // restart while armed
		add_word(OP_SAMPLE, 1'b0, 32'h8000_0001);
		drain();

		// Zero max_edges: first edge ends the run, later samples are ignored.
		program_regs(12'd0, 12'd4095, 32'hFFFF_FFFF);
		add_word(OP_START, 1'b0, 32'd100);
		add_word(OP_SAMPLE, 1'b1, 32'd150);
		add_word(OP_SAMPLE, 1'b0, 32'd200);
		drain();

		// Edge that ends the run on the count limit, then silence timeout with
		// zero limits: equal time does not fire, one more microsecond does.
		program_regs(12'd3, 12'd0, 32'd0);
		add_word(OP_START, 1'b0, 32'd1000);
		add_word(OP_SAMPLE, 1'b1, 32'd1001);
		add_word(OP_SAMPLE, 1'b0, 32'd1002);
		add_word(OP_SAMPLE, 1'b1, 32'd1003);
		add_word(OP_SAMPLE, 1'b0, 32'd1004);       // fourth edge: done
		add_word(OP_START, 1'b1, 32'd2000);
		add_word(OP_SAMPLE, 1'b1, 32'd2000);       // count 0, nothing
		add_word(OP_SAMPLE, 1'b0, 32'd2005);
		add_word(OP_SAMPLE, 1'b0, 32'd2005);       // silent for 0 us
		add_word(OP_SAMPLE, 1'b0, 32'd2006);       // silent for 1 us: timeout
		add_word(OP_SAMPLE, 1'b1, 32'd2007);       // disarmed
		drain();

		// Long back-to-back run with no idling: count limit at its top and a
		// timeout threshold that is never passed, timestamps wrap on the way.
		quiet = 1'b1;
		program_regs(12'd4095, 12'd4095, 32'd0);
		lvl = 1'b0;
		stamp_us = 32'hFFFF_FFA0;
		add_word(OP_START, lvl, stamp_us);
		for (n = 0; n < 60; n++) begin
			lvl = ~lvl;
			stamp_us = stamp_us + 32'd3;
			add_word(OP_SAMPLE, lvl, stamp_us);
		end
		drain();
		// Still armed; a lower timeout threshold now ends it, and the lower count
		// limit is only looked at on an edge.
		program_regs(12'd2, 12'd59, 32'd100);
		add_word(OP_SAMPLE, lvl, stamp_us + 32'd100);
		add_word(OP_SAMPLE, lvl, stamp_us + 32'd101);
		drain();
		quiet = 1'b0;

		// Random runs. The first one also gets the long receiver hold-off so the
		// output fills up and the input is stalled.
		pressure_on = 1'b1;
		program_regs(12'd30, 12'd3, 32'd5000);
		random_phase(110);
		drain();
		pressure_on = 1'b0;

		quiet = 1'b1;
		program_regs(12'd1, 12'd0, 32'hFFFF_FFFF);
		random_phase(90);
		drain();
		quiet = 1'b0;

		program_regs(12'd200, 12'd4095, 32'd0);
		random_phase(70);
		drain();

		program_regs(12'($urandom_range(1, 60)), 12'($urandom_range(0, 20)), $urandom);
		random_phase(60);
		drain();

		if (expected_captures.size() != 0) begin
			$error("%0d expected result words never arrived", expected_captures.size());
			errors++;
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
